// File: rtl/tdmc_pkg.sv
// ----------------------------------------------------------------------------
// tdmc_pkg
// Shared types and constants of the two-door motor controller: bit places
// of the debounced input word and of the drive word, register indexes and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tdmc_pkg;

	// field widths
	localparam int WORD_W   = 7;
	localparam int DRIVE_W  = 4;
	localparam int TIME_W   = 32;
	localparam int SETTLE_W = 16;
	localparam int COUNT_W  = SETTLE_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// bit places of the asserted input word
	localparam int B_D1_OPEN   = 0;
	localparam int B_D1_CLOSED = 1;
	localparam int B_D2_OPEN   = 2;
	localparam int B_D2_CLOSED = 3;
	localparam int B_DARK      = 4;
	localparam int B_SEPARATE  = 5;
	localparam int B_TOGGLE    = 6;

	// bit places of the drive word
	localparam int D_M1_OPEN  = 0;
	localparam int D_M1_CLOSE = 1;
	localparam int D_M2_OPEN  = 2;
	localparam int D_M2_CLOSE = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT = 1'b0,
		REG_SETTLE  = 1'b1
	} cfg_reg_t;

	// register reset values
	localparam logic [TIME_W-1:0]   TIMEOUT_RST = TIME_W'(5000);
	localparam logic [SETTLE_W-1:0] SETTLE_RST  = SETTLE_W'(1000);

	// result of one open or close command
	typedef struct packed {
		logic [DRIVE_W-1:0] drv;
		logic               hit0;
		logic               hit1;
	} cmd_t;

endpackage

// File: rtl/two_door_motor_controller.sv
// ----------------------------------------------------------------------------
// two_door_motor_controller
// Debounces seven active-low switch inputs and drives two door motors from
// edges of the debounced word, with a run-time limit on each motor.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while results are taken and
// returns one result word per sample, through the input register and then
// the result register. All state (debounce candidate and counter, stable
// word, drive bits, motor start times) is updated in the cycle in which a
// sample moves from the input register into the result register, so
// throughput is one sample per cycle as long as results are taken. An empty
// input register takes a new sample while a result waits. Configuration
// writes are always accepted and must only happen while the block is idle.
module two_door_motor_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                door1_open_pin,
	input  logic                                door1_close_pin,
	input  logic                                door2_open_pin,
	input  logic                                door2_close_pin,
	input  logic                                light_pin,
	input  logic                                separate_pin,
	input  logic                                toggle_pin,
	input  logic [tdmc_pkg::TIME_W-1:0]         now_ms,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                m1_open_drive,
	output logic                                m1_close_drive,
	output logic                                m2_open_drive,
	output logic                                m2_close_drive,
	output logic [tdmc_pkg::WORD_W-1:0]         stable_word,
	output logic                                accepted_change,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tdmc_pkg::*;

	// configuration registers
	logic [TIME_W-1:0]   timeout_q;
	logic [SETTLE_W-1:0] settle_q;

	// input register
	logic                s1_valid;
	logic [WORD_W-1:0]   word_s1;
	logic [TIME_W-1:0]   now_s1;

	// controller state
	logic [WORD_W-1:0]   stable_q;
	logic [WORD_W-1:0]   cand_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [DRIVE_W-1:0]  drive_q;
	logic [TIME_W-1:0]   start0_q;
	logic [TIME_W-1:0]   start1_q;
	logic                first_q;

	// result register
	logic                out_valid_q;
	logic [DRIVE_W-1:0]  res_drive_q;
	logic [WORD_W-1:0]   res_stable_q;
	logic                res_acc_q;

	// next-state values
	logic [WORD_W-1:0]   stable_n;
	logic [WORD_W-1:0]   cand_n;
	logic [COUNT_W-1:0]  cnt_n;
	logic [DRIVE_W-1:0]  drive_n;
	logic [TIME_W-1:0]   start0_n;
	logic [TIME_W-1:0]   start1_n;
	logic                acc_c;

	logic                advance;

	// open or close command on both motors, door 2 only when coupled
	function automatic cmd_t apply_cmd(input logic [DRIVE_W-1:0] d,
		input logic [WORD_W-1:0] w, input logic close);
		cmd_t r;
		r.drv  = d;
		r.hit0 = 1'b0;
		r.hit1 = 1'b0;
		if (close) begin
			r.drv[D_M1_OPEN] = 1'b0;
			r.drv[D_M2_OPEN] = 1'b0;
			if (!w[B_D1_CLOSED]) begin
				r.drv[D_M1_CLOSE] = 1'b1;
				r.hit0 = 1'b1;
			end
			if (!w[B_SEPARATE] && !w[B_D2_CLOSED]) begin
				r.drv[D_M2_CLOSE] = 1'b1;
				r.hit1 = 1'b1;
			end
		end else begin
			r.drv[D_M1_CLOSE] = 1'b0;
			r.drv[D_M2_CLOSE] = 1'b0;
			if (!w[B_D1_OPEN]) begin
				r.drv[D_M1_OPEN] = 1'b1;
				r.hit0 = 1'b1;
			end
			if (!w[B_SEPARATE] && !w[B_D2_OPEN]) begin
				r.drv[D_M2_OPEN] = 1'b1;
				r.hit1 = 1'b1;
			end
		end
		return r;
	endfunction

	// handshakes
	assign advance   = s1_valid && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid || advance;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			settle_q  <= SETTLE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_SETTLE:  settle_q  <= cfg_data[SETTLE_W-1:0];
				default:     ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	// input register payload, pins inverted to asserted bits
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= ~{toggle_pin, separate_pin, light_pin, door2_close_pin,
				door2_open_pin, door1_close_pin, door1_open_pin};
			now_s1  <= now_ms;
		end
	end

	// one sample: start-up rule, timeout, debounce, edge actions
	always_comb begin
		logic [TIME_W-1:0]   el0;
		logic [TIME_W-1:0]   el1;
		logic [WORD_W-1:0]   bef;
		logic [WORD_W-1:0]   aft;
		logic                tog_close;
		cmd_t                cmd;

		drive_n   = drive_q;
		start0_n  = start0_q;
		start1_n  = start1_q;
		stable_n  = stable_q;
		cand_n    = cand_q;
		cnt_n     = cnt_q;
		acc_c     = 1'b0;
		tog_close = 1'b0;
		cmd       = '0;

		// start-up: close any door between limits
		if (first_q) begin
			if (!word_s1[B_D1_OPEN] && !word_s1[B_D1_CLOSED]) begin
				drive_n[D_M1_CLOSE] = 1'b1;
				start0_n = now_s1;
			end
			if (!word_s1[B_D2_OPEN] && !word_s1[B_D2_CLOSED]) begin
				drive_n[D_M2_CLOSE] = 1'b1;
				start1_n = now_s1;
			end
		end

		// run-time limit
		el0 = now_s1 - start0_n;
		el1 = now_s1 - start1_n;
		if ((drive_n[D_M1_OPEN] || drive_n[D_M1_CLOSE]) && el0 > timeout_q) begin
			drive_n[D_M1_OPEN]  = 1'b0;
			drive_n[D_M1_CLOSE] = 1'b0;
		end
		if ((drive_n[D_M2_OPEN] || drive_n[D_M2_CLOSE]) && el1 > timeout_q) begin
			drive_n[D_M2_OPEN]  = 1'b0;
			drive_n[D_M2_CLOSE] = 1'b0;
		end

		// debounce counter, saturating one above the settle count
		if (word_s1 != cand_q) begin
			cand_n = word_s1;
			cnt_n  = '0;
		end else if (cnt_q <= {1'b0, settle_q}) begin
			cnt_n = cnt_q + COUNT_W'(1);
		end

		bef = stable_q;
		aft = cand_n;
		if (cnt_n == {1'b0, settle_q} && stable_q != cand_n) begin
			acc_c    = 1'b1;
			stable_n = cand_n;

			// toggle: limit decides, else reverse motor 1 direction
			if (!bef[B_TOGGLE] && aft[B_TOGGLE]) begin
				if (word_s1[B_D1_OPEN]) begin
					tog_close = 1'b1;
				end else if (word_s1[B_D1_CLOSED]) begin
					tog_close = 1'b0;
				end else begin
					tog_close = drive_n[D_M1_OPEN];
				end
				cmd = apply_cmd(drive_n, word_s1, tog_close);
				drive_n = cmd.drv;
				if (cmd.hit0) start0_n = now_s1;
				if (cmd.hit1) start1_n = now_s1;
			end

			// dark closes, light opens
			if (bef[B_DARK] != aft[B_DARK]) begin
				cmd = apply_cmd(drive_n, word_s1, aft[B_DARK]);
				drive_n = cmd.drv;
				if (cmd.hit0) start0_n = now_s1;
				if (cmd.hit1) start1_n = now_s1;
			end

			// limit reached stops that motor
			if ((!bef[B_D1_CLOSED] && aft[B_D1_CLOSED]) ||
				(!bef[B_D1_OPEN] && aft[B_D1_OPEN])) begin
				drive_n[D_M1_OPEN]  = 1'b0;
				drive_n[D_M1_CLOSE] = 1'b0;
			end
			if ((!bef[B_D2_CLOSED] && aft[B_D2_CLOSED]) ||
				(!bef[B_D2_OPEN] && aft[B_D2_OPEN])) begin
				drive_n[D_M2_OPEN]  = 1'b0;
				drive_n[D_M2_CLOSE] = 1'b0;
			end
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			cand_q   <= '0;
			cnt_q    <= '0;
			drive_q  <= '0;
			start0_q <= '0;
			start1_q <= '0;
			first_q  <= 1'b1;
		end else if (advance) begin
			stable_q <= stable_n;
			cand_q   <= cand_n;
			cnt_q    <= cnt_n;
			drive_q  <= drive_n;
			start0_q <= start0_n;
			start1_q <= start1_n;
			first_q  <= 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_drive_q  <= drive_n;
			res_stable_q <= stable_n;
			res_acc_q    <= acc_c;
		end
	end

	// outputs
	assign out_valid       = out_valid_q;
	assign m1_open_drive   = res_drive_q[D_M1_OPEN];
	assign m1_close_drive  = res_drive_q[D_M1_CLOSE];
	assign m2_open_drive   = res_drive_q[D_M2_OPEN];
	assign m2_close_drive  = res_drive_q[D_M2_CLOSE];
	assign stable_word     = res_stable_q;
	assign accepted_change = res_acc_q;

`ifndef SYNTH
	// a motor never drives both directions at once
	a_no_dual_drive: assert property (@(posedge clk) disable iff (!arst_n)
		!(drive_q[D_M1_OPEN] && drive_q[D_M1_CLOSE]) &&
		!(drive_q[D_M2_OPEN] && drive_q[D_M2_CLOSE]))
		else $error("motor driven in both directions");

	// an accepted change really changes the stable word
	a_acc_changes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && acc_c |=> stable_q != $past(stable_q))
		else $error("accepted change left stable word unchanged");

	// start-up rule is consumed only by a processed sample
	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(advance))
		else $error("start-up flag cleared without a sample");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");
`endif

endmodule
